// ----- hdl/salru_pkg.sv -----
// Shared types and constants of the size-aware LRU-2 admission filter.
// Used by salru_cell and by the top level size_aware_lru2_admission.
package salru_pkg;

  localparam int unsigned CACHE_ENTRIES   = 64;
  localparam int unsigned HISTORY_ENTRIES = 128;
  localparam int unsigned CCNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned HCNT_W = $clog2(HISTORY_ENTRIES + 1);

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned CNT_W  = 48;
  localparam int unsigned CAP_W  = 32;
  localparam int unsigned FAC_W  = 4;
  localparam int unsigned CUSED_W = 33;
  localparam int unsigned HUSED_W = 36;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [7:0]       EV_MAX  = '1;

  // Configuration register indexes.
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_FACTOR   = 1'b1;

  typedef enum logic [1:0] {
    ACT_PROMOTE = 2'd0,
    ACT_CACHE   = 2'd1,
    ACT_HISTORY = 2'd2,
    ACT_DROP    = 2'd3
  } action_e;

  // Operation applied to every cell of one list in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_PROMOTE = 2'd1,
    OP_POP     = 2'd2,
    OP_PUSH    = 2'd3
  } op_e;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

// ----- hdl/salru_cell.sv -----
// One entry cell of a recency list: key, size and valid bit.
// Depends on salru_pkg; neighbors are chained by the top level.
module salru_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  salru_pkg::op_e                   op_i,
  input  salru_pkg::entry_t                prev_i,
  input  logic                             next_valid_i,
  input  logic                             shift_in_i,
  input  logic [salru_pkg::KEY_W-1:0]      lookup_key_i,
  output salru_pkg::entry_t                entry_o,
  output logic                             match_o,
  output logic                             shift_o,
  output logic                             tail_o
);

  logic                          valid_q, valid_d;
  logic [salru_pkg::KEY_W-1:0]   key_q, key_d;
  logic [salru_pkg::SIZE_W-1:0]  size_q, size_d;

  assign entry_o = '{valid: valid_q, key: key_q, size: size_q};
  assign match_o = valid_q && (key_q == lookup_key_i);
  // A promotion shifts every cell from the front down to the matching one.
  assign shift_o = match_o | shift_in_i;
  assign tail_o  = valid_q && !next_valid_i;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    size_d  = size_q;
    unique case (op_i)
      salru_pkg::OP_HOLD: begin
      end
      salru_pkg::OP_PROMOTE: begin
        if (shift_o) begin
          valid_d = prev_i.valid;
          key_d   = prev_i.key;
          size_d  = prev_i.size;
        end
      end
      salru_pkg::OP_POP: begin
        if (tail_o) begin
          valid_d = 1'b0;
        end
      end
      salru_pkg::OP_PUSH: begin
        valid_d = prev_i.valid;
        key_d   = prev_i.key;
        size_d  = prev_i.size;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    size_q <= size_d;
  end

endmodule

// ----- hdl/size_aware_lru2_admission.sv -----
// Top level of the size-aware LRU-2 admission filter.
// Depends on salru_pkg and salru_cell (two chains of list cells).
//
// Requests arrive on the s_axis stream, one transfer per request, carrying
// an object key and size. Each request yields exactly one result transfer
// on the m_axis stream: hit flag, action taken, number of evicted entries
// and saturating request and hit counters.
// The block works on one request at a time. A request is captured, then
// looked up across all cells in parallel; for an insertion the tail
// entries are evicted as needed and the entry is inserted, and finally
// the result register is loaded. A hit or a drop skips the eviction step.
// The eviction loop removes one tail entry per cycle.
// Reset clears all valid bits, byte counts and counters at once and loads
// the default capacity (1 MiB) and history factor (2); no clearing pass.
// When the receiver stalls, the result stays in the output register and a
// finished request waits there until the register frees; a new request is
// still captured while the previous result waits.
// Configuration writes on cfg_we_i are taken at any clock edge and must
// only happen while no request is in progress.
module size_aware_lru2_admission (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // s_axis_tdata fields from bit 0: object_key[31:0], object_size[55:32]
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m_axis_tdata fields from bit 0: hit[0], action[2:1], evicted_count[10:3],
  // total_requests[58:11], hit_requests[106:59], zero fill up to bit 111
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned C = salru_pkg::CACHE_ENTRIES;
  localparam int unsigned H = salru_pkg::HISTORY_ENTRIES;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT,
    ST_FINISH
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [salru_pkg::CAP_W-1:0] cap_q;
  logic [salru_pkg::FAC_W-1:0] fac_q;

  // Request being processed.
  logic [salru_pkg::KEY_W-1:0]  key_q;
  logic [salru_pkg::SIZE_W-1:0] size_q;
  logic                         hist_tgt_q;  // eviction loop works on history

  // List bookkeeping.
  logic [salru_pkg::CCNT_W-1:0]  ccnt_q;
  logic [salru_pkg::HCNT_W-1:0]  hcnt_q;
  logic [salru_pkg::CUSED_W-1:0] cused_q;
  logic [salru_pkg::HUSED_W-1:0] hused_q;
  logic [salru_pkg::CNT_W-1:0]   req_cnt_q, hit_cnt_q;

  // Result being built and the output register.
  logic                  res_hit_q;
  salru_pkg::action_e    res_act_q;
  logic [7:0]            res_ev_q;
  logic                  out_valid_q;
  logic                  out_hit_q;
  salru_pkg::action_e    out_act_q;
  logic [7:0]            out_ev_q;
  logic [salru_pkg::CNT_W-1:0] out_req_q, out_hits_q;

  // Cell chains.
  salru_pkg::op_e    cop, hop;
  salru_pkg::entry_t cins, hins;
  salru_pkg::entry_t centry [C];
  salru_pkg::entry_t hentry [H];
  logic [C-1:0] cmatch, cshift, ctail;
  logic [H-1:0] hmatch, hshift, htail;

  for (genvar i = 0; i < C; i++) begin : g_cache
    salru_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cop),
      .prev_i       ((i == 0) ? cins : centry[(i == 0) ? 0 : i - 1]),
      .next_valid_i ((i == C - 1) ? 1'b0 : centry[(i == C - 1) ? i : i + 1].valid),
      .shift_in_i   ((i == C - 1) ? 1'b0 : cshift[(i == C - 1) ? i : i + 1]),
      .lookup_key_i (key_q),
      .entry_o      (centry[i]),
      .match_o      (cmatch[i]),
      .shift_o      (cshift[i]),
      .tail_o       (ctail[i])
    );
  end

  for (genvar i = 0; i < H; i++) begin : g_hist
    salru_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (hop),
      .prev_i       ((i == 0) ? hins : hentry[(i == 0) ? 0 : i - 1]),
      .next_valid_i ((i == H - 1) ? 1'b0 : hentry[(i == H - 1) ? i : i + 1].valid),
      .shift_in_i   ((i == H - 1) ? 1'b0 : hshift[(i == H - 1) ? i : i + 1]),
      .lookup_key_i (key_q),
      .entry_o      (hentry[i]),
      .match_o      (hmatch[i]),
      .shift_o      (hshift[i]),
      .tail_o       (htail[i])
    );
  end

  // Keys are unique within a list, so the matching and the tail cell can
  // be picked out by an AND-OR reduction.
  logic [salru_pkg::SIZE_W-1:0] chit_size, ctail_size, htail_size;
  logic [C-1:0] cvalid;

  always_comb begin
    chit_size  = '0;
    ctail_size = '0;
    for (int i = 0; i < C; i++) begin
      chit_size  = chit_size  | (cmatch[i] ? centry[i].size : '0);
      ctail_size = ctail_size | (ctail[i]  ? centry[i].size : '0);
      cvalid[i]  = centry[i].valid;
    end
    htail_size = '0;
    for (int i = 0; i < H; i++) begin
      htail_size = htail_size | (htail[i] ? hentry[i].size : '0);
    end
  end

  logic chit, hhit;
  assign chit = |cmatch;
  assign hhit = |hmatch;

  // Budgets and fit tests. A zero history factor counts as one.
  logic [salru_pkg::FAC_W-1:0]   fac_eff;
  logic [salru_pkg::HUSED_W-1:0] hbudget;
  logic                          size_over_cap, cache_over, hist_over;
  logic [salru_pkg::CUSED_W:0]   cneed;
  logic [salru_pkg::HUSED_W:0]   hneed;

  assign fac_eff       = (fac_q == '0) ? salru_pkg::FAC_W'(1) : fac_q;
  assign hbudget       = salru_pkg::HUSED_W'(cap_q) * salru_pkg::HUSED_W'(fac_eff);
  assign size_over_cap = salru_pkg::CAP_W'(size_q) > cap_q;
  assign cneed         = (salru_pkg::CUSED_W + 1)'(cused_q) + (salru_pkg::CUSED_W + 1)'(size_q);
  assign hneed         = (salru_pkg::HUSED_W + 1)'(hused_q) + (salru_pkg::HUSED_W + 1)'(size_q);
  assign cache_over    = cneed > (salru_pkg::CUSED_W + 1)'(cap_q);
  assign hist_over     = hneed > (salru_pkg::HUSED_W + 1)'(hbudget);

  logic tgt_over, tgt_nz, tgt_full, evict_now;
  assign tgt_over  = hist_tgt_q ? hist_over : cache_over;
  assign tgt_nz    = hist_tgt_q ? (hcnt_q != '0) : (ccnt_q != '0);
  assign tgt_full  = hist_tgt_q ? (hcnt_q == salru_pkg::HCNT_W'(H))
                                : (ccnt_q == salru_pkg::CCNT_W'(C));
  assign evict_now = (tgt_nz && tgt_over) || tgt_full;

  // Cell operations for this cycle.
  always_comb begin
    cop  = salru_pkg::OP_HOLD;
    hop  = salru_pkg::OP_HOLD;
    cins = '{valid: 1'b1, key: key_q, size: size_q};
    hins = '{valid: 1'b1, key: key_q, size: size_q};
    unique case (state_q)
      ST_LOOKUP: begin
        if (chit) begin
          cop       = salru_pkg::OP_PROMOTE;
          cins.size = chit_size;
        end
      end
      ST_EVICT: begin
        if (hist_tgt_q) begin
          hop = evict_now ? salru_pkg::OP_POP : salru_pkg::OP_PUSH;
        end else begin
          cop = evict_now ? salru_pkg::OP_POP : salru_pkg::OP_PUSH;
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_hits_q, out_req_q, out_ev_q, out_act_q, out_hit_q};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= salru_pkg::CAP_W'(1048576);
      fac_q <= salru_pkg::FAC_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        salru_pkg::REG_CAPACITY: cap_q <= cfg_wdata_i;
        salru_pkg::REG_FACTOR:   fac_q <= cfg_wdata_i[salru_pkg::FAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q  <= s_axis_tdata[31:0];
      size_q <= s_axis_tdata[55:32];
    end
  end

  // Sequencer, list bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hist_tgt_q  <= 1'b0;
      ccnt_q      <= '0;
      hcnt_q      <= '0;
      cused_q     <= '0;
      hused_q     <= '0;
      req_cnt_q   <= '0;
      hit_cnt_q   <= '0;
      res_hit_q   <= 1'b0;
      res_act_q   <= salru_pkg::ACT_PROMOTE;
      res_ev_q    <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_act_q   <= salru_pkg::ACT_PROMOTE;
      out_ev_q    <= '0;
      out_req_q   <= '0;
      out_hits_q  <= '0;
    end else begin
      // In ST_FINISH the output register is reloaded instead.
      if (out_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          res_ev_q  <= '0;
          res_hit_q <= chit;
          if (req_cnt_q != salru_pkg::CNT_MAX) begin
            req_cnt_q <= req_cnt_q + 1'b1;
          end
          priority if (chit) begin
            if (hit_cnt_q != salru_pkg::CNT_MAX) begin
              hit_cnt_q <= hit_cnt_q + 1'b1;
            end
            res_act_q <= salru_pkg::ACT_PROMOTE;
            state_q   <= ST_FINISH;
          end else if (hhit) begin
            if (size_over_cap) begin
              res_act_q <= salru_pkg::ACT_DROP;
              state_q   <= ST_FINISH;
            end else begin
              res_act_q  <= salru_pkg::ACT_CACHE;
              hist_tgt_q <= 1'b0;
              state_q    <= ST_EVICT;
            end
          end else begin
            if (hist_over && size_over_cap) begin
              res_act_q <= salru_pkg::ACT_DROP;
              state_q   <= ST_FINISH;
            end else begin
              res_act_q  <= salru_pkg::ACT_HISTORY;
              hist_tgt_q <= 1'b1;
              state_q    <= ST_EVICT;
            end
          end
        end
        ST_EVICT: begin
          if (evict_now) begin
            if (res_ev_q != salru_pkg::EV_MAX) begin
              res_ev_q <= res_ev_q + 1'b1;
            end
            if (hist_tgt_q) begin
              hcnt_q  <= hcnt_q - 1'b1;
              hused_q <= hused_q - salru_pkg::HUSED_W'(htail_size);
            end else begin
              ccnt_q  <= ccnt_q - 1'b1;
              cused_q <= cused_q - salru_pkg::CUSED_W'(ctail_size);
            end
          end else begin
            if (hist_tgt_q) begin
              hcnt_q  <= hcnt_q + 1'b1;
              hused_q <= hused_q + salru_pkg::HUSED_W'(size_q);
            end else begin
              ccnt_q  <= ccnt_q + 1'b1;
              cused_q <= cused_q + salru_pkg::CUSED_W'(size_q);
            end
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= res_hit_q;
            out_act_q   <= res_act_q;
            out_ev_q    <= res_ev_q;
            out_req_q   <= req_cnt_q;
            out_hits_q  <= hit_cnt_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Keys are unique within each list, so at most one cell matches.
  a_cache_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmatch)) else $error("cache holds a key twice");

  a_hist_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hmatch)) else $error("history holds a key twice");

  // The cache entry count tracks the valid cells.
  a_cache_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cvalid) == int'(ccnt_q)) else $error("cache count out of step");
`endif

endmodule
